[rtl/affine_rect_bounds_core_assert.svh]
// Assertion macros for the rectangle bounds core checkers.
// Each macro expects clk and arst_n in scope at the place of use.
`ifndef AFFINE_RECT_BOUNDS_CORE_ASSERT_SVH
`define AFFINE_RECT_BOUNDS_CORE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define ARB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off during reset.
`define ARB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/arb_pkg.sv]
// ----------------------------------------------------------------------------
// arb_pkg
// Shared types, register indexes and saturation helper for the rectangle
// bounds core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package arb_pkg;

	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_SCALE_XX = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHEAR_XY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHEAR_YX = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_YY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd5;

	// Q16.16 constants
	localparam logic signed [31:0] Q_ONE  = 32'sh0001_0000;
	localparam logic signed [31:0] Q_ZERO = 32'sh0000_0000;

	localparam int unsigned SUM_W = 50;

	typedef struct packed {
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] c;
		logic signed [31:0] d;
		logic signed [31:0] tx;
		logic signed [31:0] ty;
	} coef_t;

	typedef struct packed {
		logic fast;
		logic unit_x;
		logic unit_y;
	} mode_t;

	typedef struct packed {
		logic signed [31:0] nx;   // full transform, x
		logic signed [31:0] ny;   // full transform, y
		logic signed [31:0] fx;   // scaled x, saturated
		logic signed [31:0] fy;   // scaled y, saturated
		logic signed [31:0] rx;   // raw corner x
		logic signed [31:0] ry;   // raw corner y
	} lane_res_t;

	typedef struct packed {
		logic signed [31:0] bottom_y;
		logic signed [31:0] right_x;
		logic signed [31:0] top_y;
		logic signed [31:0] left_x;
	} bounds_t;

	// Clamp a wide signed value to the 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [31:0] r;
		if (v[SUM_W-1:31] != {(SUM_W-31){v[SUM_W-1]}}) begin
			r = v[SUM_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

[rtl/arb_lane.sv]
// ----------------------------------------------------------------------------
// arb_lane
// Maps one corner through the matrix: four products in the first stage,
// sums and saturation in the second.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arb_lane import arb_pkg::*; (
	input  logic               clk,
	input  logic               en_s1,
	input  logic               en_s2,
	input  coef_t              coef,
	input  logic signed [31:0] cx,
	input  logic signed [31:0] cy,
	output lane_res_t          res_s2
);

	logic signed [63:0] prod_a, prod_b, prod_c, prod_d;
	logic signed [47:0] pa_s1, pb_s1, pc_s1, pd_s1;
	logic signed [31:0] cx_s1, cy_s1;
	logic signed [SUM_W-1:0] sum_x, sum_y;

	assign prod_a = coef.a * cx;
	assign prod_b = coef.b * cx;
	assign prod_c = coef.c * cy;
	assign prod_d = coef.d * cy;

	// Drop 16 fraction bits: arithmetic shift rounds toward minus infinity
	always_ff @(posedge clk) begin
		if (en_s1) begin
			pa_s1 <= prod_a[63:16];
			pb_s1 <= prod_b[63:16];
			pc_s1 <= prod_c[63:16];
			pd_s1 <= prod_d[63:16];
			cx_s1 <= cx;
			cy_s1 <= cy;
		end
	end

	assign sum_x = SUM_W'(pa_s1) + SUM_W'(pc_s1) + SUM_W'(coef.tx);
	assign sum_y = SUM_W'(pb_s1) + SUM_W'(pd_s1) + SUM_W'(coef.ty);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			res_s2.nx <= sat32(sum_x);
			res_s2.ny <= sat32(sum_y);
			res_s2.fx <= sat32(SUM_W'(pa_s1));
			res_s2.fy <= sat32(SUM_W'(pd_s1));
			res_s2.rx <= cx_s1;
			res_s2.ry <= cy_s1;
		end
	end

endmodule

[rtl/arb_merge.sv]
// ----------------------------------------------------------------------------
// arb_merge
// Combines the four corner lanes: min/max for a general matrix, or scaled
// pairs plus offset for an axis-aligned one, ordered unless the scale is 1.0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arb_merge import arb_pkg::*; (
	input  logic      clk,
	input  logic      en_s3,
	input  logic      en_s4,
	input  coef_t     coef,
	input  mode_t     mode_s2,
	input  lane_res_t lane_s2 [4],
	output bounds_t   bounds_s4
);

	function automatic logic signed [31:0] smin(input logic signed [31:0] p,
	                                            input logic signed [31:0] q);
		return (p < q) ? p : q;
	endfunction

	function automatic logic signed [31:0] smax(input logic signed [31:0] p,
	                                            input logic signed [31:0] q);
		return (p > q) ? p : q;
	endfunction

	bounds_t gen_c, gen_s3;
	bounds_t pair_c, pair_s3;
	logic    fast_s3;

	always_comb begin
		gen_c.left_x   = smin(smin(lane_s2[0].nx, lane_s2[1].nx),
		                      smin(lane_s2[2].nx, lane_s2[3].nx));
		gen_c.right_x  = smax(smax(lane_s2[0].nx, lane_s2[1].nx),
		                      smax(lane_s2[2].nx, lane_s2[3].nx));
		gen_c.top_y    = smin(smin(lane_s2[0].ny, lane_s2[1].ny),
		                      smin(lane_s2[2].ny, lane_s2[3].ny));
		gen_c.bottom_y = smax(smax(lane_s2[0].ny, lane_s2[1].ny),
		                      smax(lane_s2[2].ny, lane_s2[3].ny));
	end

	// Lane 0 holds the first corner, lane 3 the opposite one.
	// Unit scale keeps the input order untouched.
	always_comb begin
		if (mode_s2.unit_x) begin
			pair_c.left_x  = lane_s2[0].rx;
			pair_c.right_x = lane_s2[3].rx;
		end else begin
			pair_c.left_x  = smin(lane_s2[0].fx, lane_s2[3].fx);
			pair_c.right_x = smax(lane_s2[0].fx, lane_s2[3].fx);
		end
		if (mode_s2.unit_y) begin
			pair_c.top_y    = lane_s2[0].ry;
			pair_c.bottom_y = lane_s2[3].ry;
		end else begin
			pair_c.top_y    = smin(lane_s2[0].fy, lane_s2[3].fy);
			pair_c.bottom_y = smax(lane_s2[0].fy, lane_s2[3].fy);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			gen_s3  <= gen_c;
			pair_s3 <= pair_c;
			fast_s3 <= mode_s2.fast;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			if (fast_s3) begin
				bounds_s4.left_x   <= sat32(SUM_W'(pair_s3.left_x) + SUM_W'(coef.tx));
				bounds_s4.right_x  <= sat32(SUM_W'(pair_s3.right_x) + SUM_W'(coef.tx));
				bounds_s4.top_y    <= sat32(SUM_W'(pair_s3.top_y) + SUM_W'(coef.ty));
				bounds_s4.bottom_y <= sat32(SUM_W'(pair_s3.bottom_y) + SUM_W'(coef.ty));
			end else begin
				bounds_s4 <= gen_s3;
			end
		end
	end

endmodule

[rtl/affine_rect_bounds_core.sv]
// ----------------------------------------------------------------------------
// affine_rect_bounds_core
// Axis-aligned bounds of a rectangle mapped through a Q16.16 affine matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Write the six matrix registers through cfg_we/cfg_index/cfg_data while
//   the core is idle; indexes past the list are ignored.
//   The input stream carries one rectangle per transfer (two corners), the
//   output stream one set of bounds per transfer.
//   Four corner lanes multiply in stage 1 and sum/saturate in stage 2; the
//   merge stage forms min/max or per-axis pairs in stage 3, and stage 4 adds
//   the offset on the axis-aligned path and is the output register.
//   Throughput: one rectangle per cycle while the output is not stalled;
//   each lane holds four 32x32 multipliers.
//   Reset: pipeline empties, matrix returns to identity with zero offset.
//   Stall: with m_tready low the output holds; earlier stages keep filling
//   until all four hold data, then s_tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module affine_rect_bounds_core import arb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [127:0]         s_tdata,   // first_x, first_y, second_x, second_y
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [127:0]         m_tdata    // left_x, top_y, right_x, bottom_y
);

	coef_t     coef_q;
	mode_t     mode_in, mode_s1, mode_s2;
	logic      valid_s1, valid_s2, valid_s3, valid_s4;
	logic      en_s1, en_s2, en_s3, en_s4;
	logic signed [31:0] first_x, first_y, second_x, second_y;
	logic signed [31:0] cx [4];
	logic signed [31:0] cy [4];
	lane_res_t lane_s2 [4];
	bounds_t   bounds_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.a  <= Q_ONE;
			coef_q.b  <= Q_ZERO;
			coef_q.c  <= Q_ZERO;
			coef_q.d  <= Q_ONE;
			coef_q.tx <= Q_ZERO;
			coef_q.ty <= Q_ZERO;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCALE_XX: coef_q.a  <= cfg_data;
				REG_SHEAR_XY: coef_q.b  <= cfg_data;
				REG_SHEAR_YX: coef_q.c  <= cfg_data;
				REG_SCALE_YY: coef_q.d  <= cfg_data;
				REG_OFFSET_X: coef_q.tx <= cfg_data;
				REG_OFFSET_Y: coef_q.ty <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance a stage when it is empty or the next one moves
	assign en_s4    = !valid_s4 || m_tready;
	assign en_s3    = !valid_s3 || en_s4;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign s_tready = en_s1;
	assign m_tvalid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= s_tvalid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	assign mode_in.fast   = (coef_q.b == Q_ZERO) && (coef_q.c == Q_ZERO);
	assign mode_in.unit_x = (coef_q.a == Q_ONE);
	assign mode_in.unit_y = (coef_q.d == Q_ONE);

	always_ff @(posedge clk) begin
		if (en_s1) mode_s1 <= mode_in;
		if (en_s2) mode_s2 <= mode_s1;
	end

	assign first_x  = s_tdata[31:0];
	assign first_y  = s_tdata[63:32];
	assign second_x = s_tdata[95:64];
	assign second_y = s_tdata[127:96];

	// Corner order: lane 0 first corner, lane 3 opposite corner
	assign cx[0] = first_x;
	assign cy[0] = first_y;
	assign cx[1] = second_x;
	assign cy[1] = first_y;
	assign cx[2] = first_x;
	assign cy[2] = second_y;
	assign cx[3] = second_x;
	assign cy[3] = second_y;

	for (genvar i = 0; i < 4; i++) begin : g_lane
		arb_lane u_lane (
			.clk    (clk),
			.en_s1  (en_s1),
			.en_s2  (en_s2),
			.coef   (coef_q),
			.cx     (cx[i]),
			.cy     (cy[i]),
			.res_s2 (lane_s2[i])
		);
	end

	arb_merge u_merge (
		.clk       (clk),
		.en_s3     (en_s3),
		.en_s4     (en_s4),
		.coef      (coef_q),
		.mode_s2   (mode_s2),
		.lane_s2   (lane_s2),
		.bounds_s4 (bounds_s4)
	);

	assign m_tdata = bounds_s4;

endmodule

[rtl/arb_checker.sv]
// ----------------------------------------------------------------------------
// arb_checker
// Port-level checks of the rectangle bounds core pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "affine_rect_bounds_core_assert.svh"

module arb_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata
);

	// A result waiting on the output holds still
	`ARB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output changed while stalled")

	// An empty output stage means the whole pipe can take a transfer
	`ARB_ASSERT_NOW(a_idle_ready, !m_tvalid, s_tready, "input blocked with empty output")

	// Input back-pressure only ever comes from a stalled output
	`ARB_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid && !m_tready, "input blocked without output stall")

	// An accepted rectangle reaches m_tvalid if m_tready is high while it moves down the pipe
	`ARB_ASSERT_NEXT(a_latency, (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 1'b1, m_tvalid, "result missing after pipeline latency")

endmodule

bind affine_rect_bounds_core arb_checker u_arb_checker (.*);

[bench/tb_affine_rect_bounds_core.sv]
// ----------------------------------------------------------------------------
// tb_affine_rect_bounds_core
// Drives rectangles through the affine bounds core and checks every output
// transfer against fixed expected bounds or a local Q16.16 model of the
// matrix, fast axis path and general four-corner path, under changing
// matrix settings and random backpressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_affine_rect_bounds_core;
	import arb_pkg::*;

	localparam int STALL_LIMIT     = 2000;
	localparam int ITEMS_PER_PHASE = 88;
	localparam int DRAIN_CYCLES    = 8;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam logic signed [31:0] MAX32     = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] MIN32     = 32'sh8000_0000;
	localparam logic signed [31:0] NEG_ONE_Q = 32'shFFFF_0000;
	localparam logic signed [31:0] NEG_LSB   = 32'shFFFF_FFFF;

	typedef struct packed {
		logic signed [31:0] second_y;
		logic signed [31:0] second_x;
		logic signed [31:0] first_y;
		logic signed [31:0] first_x;
	} rect_t;

	typedef enum logic {ROW_CFG, ROW_RECT} row_kind_t;

	typedef struct {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   reg_idx;
		logic [31:0]            reg_val;
		rect_t                  rect;
		bit                     known;
		bounds_t                want;
	} stim_row_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data  = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [127:0]         s_tdata   = '0;   // first_x, first_y, second_x, second_y
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [127:0]         m_tdata;          // left_x, top_y, right_x, bottom_y

	coef_t       matrix;
	bounds_t     bounds_due[$];
	stim_row_t   dir_rows[$];
	int          snd_idle;
	int          rcv_idle;
	int          mismatch_count = 0;
	int          out_count      = 0;
	int          quiet_cycles   = 0;

	affine_rect_bounds_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Q16.16 product, floor of the exact product over 2^16
	function automatic logic signed [63:0] qmul(logic signed [31:0] w, logic signed [31:0] v);
		logic signed [63:0] w64, v64;
		w64 = w;
		v64 = v;
		return (w64 * v64) >>> 16;
	endfunction

	function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
		logic signed [63:0] hi, lo;
		hi = MAX32;
		lo = MIN32;
		if (v > hi) return MAX32;
		if (v < lo) return MIN32;
		return v[31:0];
	endfunction

	// One axis of the shear-free path: scale and order unless the scale is 1.0, then add the offset
	function automatic void fit_axis(input logic signed [31:0] scale,
			input logic signed [31:0] off, inout logic signed [31:0] lo,
			inout logic signed [31:0] hi);
		logic signed [31:0] u, v;
		logic signed [63:0] acc;
		if (scale != Q_ONE) begin
			u = clamp32(qmul(lo, scale));
			v = clamp32(qmul(hi, scale));
			lo = (u < v) ? u : v;
			hi = (u < v) ? v : u;
		end
		acc = lo;
		acc = acc + off;
		lo = clamp32(acc);
		acc = hi;
		acc = acc + off;
		hi = clamp32(acc);
	endfunction

	function automatic bounds_t map_rect_bounds(rect_t r, coef_t m);
		bounds_t            res;
		logic signed [31:0] x1, x2, y1, y2, cx, cy, nx, ny;
		logic signed [63:0] acc;
		int                 i;
		x1 = r.first_x;
		y1 = r.first_y;
		x2 = r.second_x;
		y2 = r.second_y;
		res = '0;
		if (m.b == Q_ZERO && m.c == Q_ZERO) begin
			fit_axis(m.a, m.tx, x1, x2);
			fit_axis(m.d, m.ty, y1, y2);
			res.left_x   = x1;
			res.right_x  = x2;
			res.top_y    = y1;
			res.bottom_y = y2;
		end else begin
			for (i = 0; i < 4; i++) begin
				cx = i[0] ? x2 : x1;
				cy = i[1] ? y2 : y1;
				acc = m.tx;
				acc = acc + qmul(m.a, cx) + qmul(m.c, cy);
				nx = clamp32(acc);
				acc = m.ty;
				acc = acc + qmul(m.b, cx) + qmul(m.d, cy);
				ny = clamp32(acc);
				if (i == 0 || nx < res.left_x)   res.left_x   = nx;
				if (i == 0 || nx > res.right_x)  res.right_x  = nx;
				if (i == 0 || ny < res.top_y)    res.top_y    = ny;
				if (i == 0 || ny > res.bottom_y) res.bottom_y = ny;
			end
		end
		return res;
	endfunction

	function automatic logic signed [31:0] rand_span(int unsigned span);
		return 32'(int'($urandom_range(2 * span, 0)) - int'(span));
	endfunction

	function automatic logic signed [31:0] rand_coord();
		logic signed [31:0] v;
		case ($urandom_range(3))
			0, 1: v = rand_span(32'h0040_0000);
			2: v = $urandom;
			default: begin
				case ($urandom_range(5))
					0: v = MIN32;
					1: v = MAX32;
					2: v = Q_ZERO;
					3: v = NEG_LSB;
					4: v = Q_ONE;
					default: v = NEG_ONE_Q;
				endcase
			end
		endcase
		return v;
	endfunction

	function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		stim_row_t row;
		row = '{kind: ROW_CFG, reg_idx: idx, reg_val: val, rect: '0, known: 1'b0, want: '0};
		dir_rows.push_back(row);
	endfunction

	function automatic void add_rect(logic [31:0] x1, logic [31:0] y1, logic [31:0] x2,
			logic [31:0] y2);
		stim_row_t row;
		row = '{kind: ROW_RECT, reg_idx: '0, reg_val: '0, rect: {y2, x2, y1, x1},
			known: 1'b0, want: '0};
		dir_rows.push_back(row);
	endfunction

	function automatic void add_known(logic [31:0] x1, logic [31:0] y1, logic [31:0] x2,
			logic [31:0] y2, logic [31:0] l, logic [31:0] t, logic [31:0] r,
			logic [31:0] b);
		stim_row_t row;
		row = '{kind: ROW_RECT, reg_idx: '0, reg_val: '0, rect: {y2, x2, y1, x1},
			known: 1'b1, want: {b, r, t, l}};
		dir_rows.push_back(row);
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_bound(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got)
			report_mismatch($sformatf("result %0d %s: expected %h, got %h",
				out_count, name, want, got));
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SCALE_XX: matrix.a  = val;
			REG_SHEAR_XY: matrix.b  = val;
			REG_SHEAR_YX: matrix.c  = val;
			REG_SCALE_YY: matrix.d  = val;
			REG_OFFSET_X: matrix.tx = val;
			REG_OFFSET_Y: matrix.ty = val;
			default: ;
		endcase
	endtask

	// Drop valid and hold until every pending result has been taken
	task automatic wait_for_bounds();
		s_tvalid <= 1'b0;
		while (bounds_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic load_matrix(coef_t m);
		write_reg(REG_SCALE_XX, m.a);
		write_reg(REG_SHEAR_XY, m.b);
		write_reg(REG_SHEAR_YX, m.c);
		write_reg(REG_SCALE_YY, m.d);
		write_reg(REG_OFFSET_X, m.tx);
		write_reg(REG_OFFSET_Y, m.ty);
	endtask

	task automatic send_rect(rect_t r, bit known, bounds_t want);
		while ($urandom_range(99) < snd_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= r;
		do
			@(posedge clk);
		while (!s_tready);
		bounds_due.push_back(known ? want : map_rect_bounds(r, matrix));
	endtask

	always @(posedge clk) begin
		bounds_t want;
		bounds_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (bounds_due.size() == 0) begin
					report_mismatch($sformatf("result %0d with no rectangle pending: %h",
						out_count, m_tdata));
				end else begin
					want = bounds_due.pop_front();
					check_bound("left_x", want.left_x, got.left_x);
					check_bound("top_y", want.top_y, got.top_y);
					check_bound("right_x", want.right_x, got.right_x);
					check_bound("bottom_y", want.bottom_y, got.bottom_y);
				end
				out_count++;
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		m_tready <= ($urandom_range(99) >= rcv_idle);
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		rect_t r;
		coef_t m;
		matrix = '{a: Q_ONE, b: Q_ZERO, c: Q_ZERO, d: Q_ONE, tx: Q_ZERO, ty: Q_ZERO};
		snd_idle = 26;
		rcv_idle = 79;

		// Identity after reset: bounds pass through, order kept
		add_known(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
			32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000);
		add_known(32'h0005_0000, NEG_ONE_Q, 32'hFFFD_0000, 32'h0007_0000,
			32'h0005_0000, NEG_ONE_Q, 32'hFFFD_0000, 32'h0007_0000);
		add_known(MIN32, MAX32, MAX32, MIN32, MIN32, MAX32, MAX32, MIN32);
		// Writes past the register list leave the matrix alone
		add_cfg(REG_SPARE_LO, 32'h1234_5678);
		add_cfg(REG_SPARE_HI, 32'hDEAD_BEEF);
		add_known(Q_ZERO, NEG_LSB, NEG_LSB, Q_ZERO, Q_ZERO, NEG_LSB, NEG_LSB, Q_ZERO);
		// Offset saturation on unit axes
		add_cfg(REG_OFFSET_X, MAX32);
		add_cfg(REG_OFFSET_Y, MIN32);
		add_known(32'h0000_0001, NEG_LSB, Q_ZERO, Q_ZERO, MAX32, MIN32, MAX32, MIN32);
		add_known(MIN32, MAX32, MAX32, MIN32, NEG_LSB, NEG_LSB, MAX32, MIN32);
		// Scale 2.0 on x, -1.0 on y: pairs come out ordered
		add_cfg(REG_OFFSET_X, Q_ZERO);
		add_cfg(REG_OFFSET_Y, Q_ZERO);
		add_cfg(REG_SCALE_XX, 32'h0002_0000);
		add_cfg(REG_SCALE_YY, NEG_ONE_Q);
		add_known(32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000,
			32'h0002_0000, 32'hFFFE_0000, 32'h0006_0000, NEG_ONE_Q);
		add_known(MAX32, MIN32, MIN32, MAX32, MIN32, 32'h8000_0001, MAX32, MAX32);
		add_rect(NEG_LSB, NEG_LSB, 32'h0000_0001, 32'h0000_0001);
		// Rounding toward minus infinity, most negative scale
		add_cfg(REG_SCALE_XX, 32'h0000_8000);
		add_cfg(REG_SCALE_YY, MIN32);
		add_rect(NEG_LSB, 32'h0000_0003, 32'h0000_0001, 32'hFFFF_FFFD);
		add_rect(MAX32, MAX32, MIN32, MIN32);
		// Unit x keeps order, zero scale on y
		add_cfg(REG_SCALE_XX, Q_ONE);
		add_cfg(REG_SCALE_YY, Q_ZERO);
		add_cfg(REG_OFFSET_Y, 32'h0000_1234);
		add_known(32'h0009_0000, 32'h1234_5678, 32'h0002_0000, 32'hEDCB_A988,
			32'h0009_0000, 32'h0000_1234, 32'h0002_0000, 32'h0000_1234);
		// Quarter turn: x' = -y, y' = x
		add_cfg(REG_SCALE_XX, Q_ZERO);
		add_cfg(REG_SHEAR_XY, Q_ONE);
		add_cfg(REG_SHEAR_YX, NEG_ONE_Q);
		add_cfg(REG_OFFSET_Y, Q_ZERO);
		add_known(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0005_0000,
			32'hFFFB_0000, 32'h0001_0000, 32'hFFFE_0000, 32'h0003_0000);
		add_rect(MIN32, MAX32, MAX32, MIN32);
		add_rect(NEG_LSB, 32'h0000_0001, 32'h0000_0001, NEG_LSB);
		// One shear term alone still takes the four-corner path
		add_cfg(REG_SHEAR_YX, Q_ZERO);
		add_cfg(REG_SCALE_XX, 32'h0001_8000);
		add_cfg(REG_SCALE_YY, Q_ONE);
		add_cfg(REG_OFFSET_X, 32'hFFFF_8000);
		add_rect(32'h0001_0000, 32'hFFFE_0000, NEG_ONE_Q, 32'h0004_0000);
		add_rect(MAX32, MIN32, MIN32, MAX32);
		// Every term at the top, then at the bottom of the range
		add_cfg(REG_SCALE_XX, MAX32);
		add_cfg(REG_SHEAR_XY, MAX32);
		add_cfg(REG_SHEAR_YX, MAX32);
		add_cfg(REG_SCALE_YY, MAX32);
		add_cfg(REG_OFFSET_X, MAX32);
		add_cfg(REG_OFFSET_Y, MAX32);
		add_rect(MAX32, MAX32, MIN32, MIN32);
		add_known(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, MAX32, MAX32, MAX32, MAX32);
		add_cfg(REG_SCALE_XX, MIN32);
		add_cfg(REG_SHEAR_XY, MIN32);
		add_cfg(REG_SHEAR_YX, MIN32);
		add_cfg(REG_SCALE_YY, MIN32);
		add_cfg(REG_OFFSET_X, MIN32);
		add_cfg(REG_OFFSET_Y, MIN32);
		add_rect(MIN32, MIN32, MAX32, MAX32);
		add_rect(32'h0000_0001, NEG_LSB, NEG_LSB, 32'h0000_0001);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k]) begin
			if (dir_rows[k].kind == ROW_CFG) begin
				wait_for_bounds();
				write_reg(dir_rows[k].reg_idx, dir_rows[k].reg_val);
			end else begin
				send_rect(dir_rows[k].rect, dir_rows[k].known, dir_rows[k].want);
			end
		end

		for (int phase = 0; phase < 6; phase++) begin
			case (phase / 2)
				0: begin
					snd_idle = 26;
					rcv_idle = 79;
				end
				1: begin
					snd_idle = 79;
					rcv_idle = 26;
				end
				default: begin
					snd_idle = 0;
					rcv_idle = 0;
				end
			endcase
			case (phase)
				0: m = '{a: rand_span(32'h0004_0000), b: Q_ZERO, c: Q_ZERO,
					d: rand_span(32'h0004_0000), tx: rand_span(32'h0040_0000),
					ty: rand_span(32'h0040_0000)};
				1: m = '{a: rand_span(32'h0004_0000), b: rand_span(32'h0004_0000),
					c: rand_span(32'h0004_0000), d: rand_span(32'h0004_0000),
					tx: rand_span(32'h0040_0000), ty: rand_span(32'h0040_0000)};
				2: m = '{a: Q_ONE, b: Q_ZERO, c: Q_ZERO, d: $urandom, tx: $urandom,
					ty: $urandom};
				3: m = '{a: $urandom, b: $urandom, c: $urandom, d: $urandom,
					tx: $urandom, ty: $urandom};
				4: m = '{a: $urandom, b: Q_ZERO, c: Q_ZERO, d: $urandom, tx: $urandom,
					ty: $urandom};
				default: m = '{a: rand_span(32'h0004_0000), b: Q_ZERO,
					c: rand_span(32'h0004_0000), d: rand_span(32'h0004_0000),
					tx: rand_span(32'h0040_0000), ty: rand_span(32'h0040_0000)};
			endcase
			// Keep the general-path phases off the shear-free path
			if (phase % 2 == 1 && m.b == Q_ZERO && m.c == Q_ZERO)
				m.c = Q_ONE;
			// Pause the input until the pipeline is empty before reloading
			wait_for_bounds();
			load_matrix(m);
			repeat (ITEMS_PER_PHASE) begin
				r.first_x  = rand_coord();
				r.first_y  = rand_coord();
				r.second_x = rand_coord();
				r.second_y = rand_coord();
				send_rect(r, 1'b0, '0);
			end
		end

		s_tvalid <= 1'b0;
		while (bounds_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/arb_pkg.sv
rtl/arb_lane.sv
rtl/arb_merge.sv
rtl/affine_rect_bounds_core.sv
rtl/arb_checker.sv
bench/tb_affine_rect_bounds_core.sv
